FILE: sv/rbd_pkg.sv
package rbd_pkg;

    localparam int DEPTH     = 1024;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int WORD_W    = 32;
    localparam int KIND_W    = 3;
    localparam int STAT_W    = 2;
    localparam int OUT_CNT_W = 11;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic signed [WORD_W-1:0] WORD_NONE = -32'sd1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FILL
    } t_state;

endpackage

FILE: sv/ring_buffer_deque.sv
// channel  | valid        | ready        | payload
// ---------+--------------+--------------+------------------------------------------
// input    | i_in_valid   | o_in_ready   | i_kind, i_push_value
// output   | o_out_valid  | i_out_ready  | o_popped_value, o_status, o_entry_count,
//          |              |              | o_is_empty, o_front_value, o_back_value
//
// push, query, rejected ops and pops that leave the deque empty: result registered on acceptance
// a pop that leaves words behind: its result waits in the fetch state on the registered read port
// of the word store that fetches the new front or back word
// reset clears indices, count, state and output valid; store contents stay undefined
// input ready drops during the fetch cycle and while a result waits with i_out_ready low
module ring_buffer_deque (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic        [rbd_pkg::KIND_W-1:0]    i_kind,
    input  logic signed [rbd_pkg::WORD_W-1:0]    i_push_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rbd_pkg::WORD_W-1:0]    o_popped_value,
    output logic        [rbd_pkg::STAT_W-1:0]    o_status,
    output logic        [rbd_pkg::OUT_CNT_W-1:0] o_entry_count,
    output logic                                 o_is_empty,
    output logic signed [rbd_pkg::WORD_W-1:0]    o_front_value,
    output logic signed [rbd_pkg::WORD_W-1:0]    o_back_value
);

    // circular index helpers, wrap at the store depth
    function automatic logic [rbd_pkg::IDX_W-1:0] idx_inc(input logic [rbd_pkg::IDX_W-1:0] i);
        return (i == rbd_pkg::IDX_W'(rbd_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [rbd_pkg::IDX_W-1:0] idx_dec(input logic [rbd_pkg::IDX_W-1:0] i);
        return (i == '0) ? rbd_pkg::IDX_W'(rbd_pkg::DEPTH - 1) : i - 1'b1;
    endfunction

    // word store, one write and one registered read per cycle
    logic signed [rbd_pkg::WORD_W-1:0] r_mem [rbd_pkg::DEPTH];
    logic signed [rbd_pkg::WORD_W-1:0] r_rdata;

    // pointer state plus cached end words, so only pops ever need a read
    rbd_pkg::t_state                   r_state, n_state;
    logic        [rbd_pkg::IDX_W-1:0]  r_head, n_head;
    logic        [rbd_pkg::IDX_W-1:0]  r_tail, n_tail;
    logic        [rbd_pkg::CNT_W-1:0]  r_count, n_count;
    logic signed [rbd_pkg::WORD_W-1:0] r_front_val, n_front_val;
    logic signed [rbd_pkg::WORD_W-1:0] r_back_val, n_back_val;
    logic                              r_fill_front, n_fill_front;

    // result register; count, empty and end words come straight from the state
    logic                              r_out_valid;
    logic signed [rbd_pkg::WORD_W-1:0] r_popped, n_popped;
    logic        [rbd_pkg::STAT_W-1:0] r_status, n_status;

    logic                              w_accept;
    logic                              w_we;
    logic                              w_re;
    logic        [rbd_pkg::IDX_W-1:0]  w_waddr;
    logic        [rbd_pkg::IDX_W-1:0]  w_raddr;
    logic                              w_full;
    logic                              w_empty;

    assign w_full   = (r_count == rbd_pkg::CNT_W'(rbd_pkg::DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_accept = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rbd_pkg::ST_IDLE: begin
                if (w_accept && w_re) begin
                    n_state = rbd_pkg::ST_FILL;
                end
            end
            rbd_pkg::ST_FILL: begin
                n_state = rbd_pkg::ST_IDLE;
            end
            default: begin
                n_state = rbd_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb begin
        o_in_ready  = (r_state == rbd_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
        o_out_valid = r_out_valid;
    end

    // transaction decode: index moves, store access, result fields
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_front_val  = r_front_val;
        n_back_val   = r_back_val;
        n_fill_front = r_fill_front;
        n_popped     = rbd_pkg::WORD_NONE;
        n_status     = rbd_pkg::STAT_DONE;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_waddr      = r_tail;
        w_raddr      = r_head;
        case (i_kind)
            rbd_pkg::KIND_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = rbd_pkg::STAT_FULL;
                end else begin
                    n_head      = idx_dec(r_head);
                    w_we        = 1'b1;
                    w_waddr     = n_head;
                    n_count     = r_count + 1'b1;
                    n_front_val = i_push_value;
                    if (w_empty) begin
                        n_back_val = i_push_value;
                    end
                end
            end
            rbd_pkg::KIND_PUSH_BACK: begin
                if (w_full) begin
                    n_status = rbd_pkg::STAT_FULL;
                end else begin
                    w_we       = 1'b1;
                    w_waddr    = r_tail;
                    n_tail     = idx_inc(r_tail);
                    n_count    = r_count + 1'b1;
                    n_back_val = i_push_value;
                    if (w_empty) begin
                        n_front_val = i_push_value;
                    end
                end
            end
            rbd_pkg::KIND_POP_FRONT: begin
                if (w_empty) begin
                    n_status = rbd_pkg::STAT_EMPTY;
                end else begin
                    n_popped     = r_front_val;
                    n_head       = idx_inc(r_head);
                    n_count      = r_count - 1'b1;
                    // fetch the new front word unless the deque just drained
                    w_re         = (n_count != '0);
                    w_raddr      = n_head;
                    n_fill_front = 1'b1;
                end
            end
            rbd_pkg::KIND_POP_BACK: begin
                if (w_empty) begin
                    n_status = rbd_pkg::STAT_EMPTY;
                end else begin
                    n_popped     = r_back_val;
                    n_tail       = idx_dec(r_tail);
                    n_count      = r_count - 1'b1;
                    w_re         = (n_count != '0);
                    w_raddr      = idx_dec(n_tail);
                    n_fill_front = 1'b0;
                end
            end
            default: begin
                // query and unused codes leave everything as is
            end
        endcase
    end

    // word store
    always_ff @(posedge i_clk) begin
        if (w_accept && w_we) begin
            r_mem[w_waddr] <= i_push_value;
        end
        if (w_accept && w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbd_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                // a pop that needs a fetch shows its result only after the fetch state
                r_out_valid <= !w_re;
            end else if (r_state == rbd_pkg::ST_FILL) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_front_val  <= n_front_val;
            r_back_val   <= n_back_val;
            r_fill_front <= n_fill_front;
            r_popped     <= n_popped;
            r_status     <= n_status;
        end else if (r_state == rbd_pkg::ST_FILL) begin
            if (r_fill_front) begin
                r_front_val <= r_rdata;
            end else begin
                r_back_val <= r_rdata;
            end
        end
    end

    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_entry_count  = rbd_pkg::OUT_CNT_W'(r_count);
    assign o_is_empty     = w_empty;
    assign o_front_value  = w_empty ? rbd_pkg::WORD_NONE : r_front_val;
    assign o_back_value   = w_empty ? rbd_pkg::WORD_NONE : r_back_val;

    // count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rbd_pkg::CNT_W'(rbd_pkg::DEPTH))
        else $error("entry count exceeds store depth");

    // during the fetch cycle no result is shown and no transaction is taken
    a_fill_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbd_pkg::ST_FILL) |-> (!r_out_valid && !o_in_ready))
        else $error("result or input open during fetch cycle");

    // a fetch cycle always ends in a valid result
    a_fill_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbd_pkg::ST_FILL) |=> (r_out_valid && r_state == rbd_pkg::ST_IDLE))
        else $error("fetch cycle did not produce a result");

    // a rejected push leaves the count unchanged
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && (i_kind == rbd_pkg::KIND_PUSH_FRONT
            || i_kind == rbd_pkg::KIND_PUSH_BACK)) |=> $stable(r_count))
        else $error("push into full deque changed the count");

endmodule
